>>> design/assert_macros.svh
// Shared assertion forms; clk and rst are taken from the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition implies property in the same cycle.
`define CHK_SAME(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("assertion failed: same-cycle check");

// Condition implies property in the next cycle.
`define CHK_NEXT(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("assertion failed: next-cycle check");

`endif

>>> design/rlfe_pkg.sv
`timescale 1ns / 1ps
package rlfe_pkg;

  localparam int LEVEL_W = 8;
  localparam int ACC_W   = 16;
  localparam int QUO_W   = 15;
  localparam int NCH     = 3;

  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_START = 2'd1;
  localparam logic [1:0] REQ_SET   = 2'd2;

  localparam logic [ACC_W-1:0] ROUND_HALF = 16'd64;

  typedef struct packed {
    logic               start;
    logic [QUO_W-1:0]   dividend;
    logic [LEVEL_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quotient;
  } div_rsp_t;

endpackage

>>> design/rlfe_div.sv
`timescale 1ns / 1ps
module rlfe_div
  import rlfe_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic               busy;
  logic               done;
  logic [3:0]         cnt;
  logic [QUO_W-1:0]   quo;
  logic [LEVEL_W-1:0] rem;
  logic [LEVEL_W-1:0] dvs;
  logic [LEVEL_W:0]   trial;
  logic [LEVEL_W:0]   diff;
  logic               ge;

  // one quotient bit per cycle: shift the dividend out, the quotient in
  assign trial = {rem, quo[QUO_W-1]};
  assign diff  = trial - {1'b0, dvs};
  assign ge    = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == 4'(QUO_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.dividend;
      rem <= '0;
      dvs <= req.divisor;
    end else if (busy) begin
      quo <= {quo[QUO_W-2:0], ge};
      rem <= ge ? diff[LEVEL_W-1:0] : trial[LEVEL_W-1:0];
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

>>> design/rgb_linear_fade_engine_top.sv
`timescale 1ns / 1ps
// RGB linear fade engine.
// Input channel (in_valid/in_ready) takes one request word: req_type, a colour
// and fade_steps. Output channel (out_valid/out_ready) returns one result word
// per request: the three levels shown after it and the fading flag.
// A tick, a set or an ignored request goes from acceptance through S_EXEC and
// S_EMIT to out_valid. A start with a nonzero step count runs three divisions
// on one bit-serial divider, one channel after another (S_LAUNCH, S_DIV).
// The next request can be taken in the same cycle in which out_valid rises.
// One request is worked on at a time; in_ready is high whenever the sequencer
// is idle, even while the previous result still waits in the output register.
// If the receiver stalls, the finished result of the next request is held
// until the output register frees, and no further request is taken.
// Reset clears all levels, accumulators, increments and the tick count to
// zero and empties the output register; the first request may follow at once.
module rgb_linear_fade_engine_top
  import rlfe_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         req_type,
  input  logic [LEVEL_W-1:0] in_red,
  input  logic [LEVEL_W-1:0] in_green,
  input  logic [LEVEL_W-1:0] in_blue,
  input  logic [LEVEL_W-1:0] fade_steps,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [LEVEL_W-1:0] out_red,
  output logic [LEVEL_W-1:0] out_green,
  output logic [LEVEL_W-1:0] out_blue,
  output logic               fading
);

`include "assert_macros.svh"

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_LAUNCH = 3'd2;
  localparam logic [2:0] S_DIV    = 3'd3;
  localparam logic [2:0] S_EMIT   = 3'd4;

  logic [2:0]         state;
  logic [1:0]         ch;
  logic               neg;
  logic [1:0]         req_q;
  logic [LEVEL_W-1:0] col_q [NCH];
  logic [LEVEL_W-1:0] steps_q;

  logic [ACC_W-1:0]   accum [NCH];
  logic [ACC_W-1:0]   increment [NCH];
  logic [LEVEL_W-1:0] target_level [NCH];
  logic [LEVEL_W-1:0] current_level [NCH];
  logic [LEVEL_W-1:0] ticks_left;

  logic [ACC_W-1:0]   acc_sum [NCH];
  logic [ACC_W-1:0]   acc_rnd [NCH];
  logic [LEVEL_W-1:0] cur_ch;
  logic [LEVEL_W-1:0] tgt_ch;
  logic               neg_ch;
  logic [LEVEL_W-1:0] mag_ch;
  logic [ACC_W-1:0]   quo_ext;
  logic               out_free;

  div_req_t div_req;
  div_rsp_t div_rsp;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      acc_sum[c] = accum[c] + increment[c];
      acc_rnd[c] = acc_sum[c] + ROUND_HALF;
    end
  end

  assign cur_ch  = current_level[ch];
  assign tgt_ch  = col_q[ch];
  assign neg_ch  = tgt_ch < cur_ch;
  assign mag_ch  = neg_ch ? (cur_ch - tgt_ch) : (tgt_ch - cur_ch);
  assign quo_ext = {1'b0, div_rsp.quotient};

  assign div_req.start    = (state == S_LAUNCH);
  assign div_req.dividend = {mag_ch, 7'd0};
  assign div_req.divisor  = steps_q;

  rlfe_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      ch         <= '0;
      out_valid  <= 1'b0;
      ticks_left <= '0;
      for (int c = 0; c < NCH; c++) begin
        accum[c]         <= '0;
        increment[c]     <= '0;
        target_level[c]  <= '0;
        current_level[c] <= '0;
      end
    end else begin
      if (state == S_EMIT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          state <= S_EMIT;
          case (req_q)
            REQ_TICK: begin
              if (ticks_left != '0) begin
                ticks_left <= ticks_left - 8'd1;
                for (int c = 0; c < NCH; c++) begin
                  accum[c] <= acc_sum[c];
                  current_level[c] <= (ticks_left == 8'd1) ? target_level[c]
                                                            : acc_rnd[c][14:7];
                end
              end
            end
            REQ_START: begin
              if (steps_q != '0) begin
                ch    <= '0;
                state <= S_LAUNCH;
              end
            end
            REQ_SET: begin
              ticks_left <= '0;
              for (int c = 0; c < NCH; c++) begin
                current_level[c] <= col_q[c];
                target_level[c]  <= col_q[c];
                accum[c]         <= {1'b0, col_q[c], 7'd0};
                increment[c]     <= '0;
              end
            end
            default: begin
            end
          endcase
        end
        S_LAUNCH: begin
          neg   <= neg_ch;
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_rsp.done) begin
            increment[ch]    <= neg ? (16'd0 - quo_ext) : quo_ext;
            accum[ch]        <= {1'b0, cur_ch, 7'd0};
            target_level[ch] <= tgt_ch;
            if (ch == 2'(NCH - 1)) begin
              ticks_left <= steps_q;
              state      <= S_EMIT;
            end else begin
              ch    <= ch + 2'd1;
              state <= S_LAUNCH;
            end
          end
        end
        S_EMIT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_q    <= req_type;
      col_q[0] <= in_red;
      col_q[1] <= in_green;
      col_q[2] <= in_blue;
      steps_q  <= fade_steps;
    end
    if (state == S_EMIT && out_free) begin
      out_red   <= current_level[0];
      out_green <= current_level[1];
      out_blue  <= current_level[2];
      fading    <= (ticks_left != '0);
    end
  end

  `CHK_SAME(a_div_only_start, state == S_DIV, req_q == REQ_START && steps_q != '0)
  `CHK_SAME(a_done_in_div, div_rsp.done, state == S_DIV)
  `CHK_NEXT(a_emit_loads_out, state == S_EMIT && out_free, out_valid && state == S_IDLE)

endmodule

>>> tb/tb_rgb_linear_fade_engine_top.sv
`timescale 1ns / 1ps

typedef struct {
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic       fading;
} shown_colour_t;

class fade_scoreboard;
  logic [15:0]   acc[3];
  logic [15:0]   inc[3];
  logic [7:0]    tgt[3];
  logic [7:0]    lvl[3];
  logic [7:0]    ticks_left;
  shown_colour_t colours_due[$];
  int            errors;

  function new();
    for (int c = 0; c < 3; c++) begin
      acc[c] = '0;
      inc[c] = '0;
      tgt[c] = '0;
      lvl[c] = '0;
    end
    ticks_left = '0;
    errors = 0;
  endfunction

  function int pending();
    return colours_due.size();
  endfunction

  function void note_request(logic [1:0] kind, logic [7:0] r, logic [7:0] g, logic [7:0] b,
                             logic [7:0] steps);
    logic [7:0]    col[3];
    int            from_q;
    int            to_q;
    int            quo;
    logic [15:0]   rounded;
    shown_colour_t exp_col;
    col[0] = r;
    col[1] = g;
    col[2] = b;
    if (kind == rlfe_pkg::REQ_TICK) begin
      if (ticks_left != 0) begin
        ticks_left = ticks_left - 8'd1;
        for (int c = 0; c < 3; c++) begin
          acc[c] = acc[c] + inc[c];
          rounded = acc[c] + 16'd64;
          lvl[c] = (ticks_left == 0) ? tgt[c] : rounded[14:7];
        end
      end
    end else if (kind == rlfe_pkg::REQ_START) begin
      if (steps != 0) begin
        for (int c = 0; c < 3; c++) begin
          from_q = int'(lvl[c]) * 128;
          to_q = int'(col[c]) * 128;
          quo = (to_q - from_q) / int'(steps);
          acc[c] = from_q[15:0];
          inc[c] = quo[15:0];
          tgt[c] = col[c];
        end
        ticks_left = steps;
      end
    end else if (kind == rlfe_pkg::REQ_SET) begin
      for (int c = 0; c < 3; c++) begin
        lvl[c] = col[c];
        tgt[c] = col[c];
        acc[c] = {1'b0, col[c], 7'd0};
        inc[c] = '0;
      end
      ticks_left = '0;
    end
    exp_col.red = lvl[0];
    exp_col.green = lvl[1];
    exp_col.blue = lvl[2];
    exp_col.fading = (ticks_left != 0);
    colours_due.push_back(exp_col);
  endfunction

  function void check_result(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic f);
    shown_colour_t exp_col;
    if (colours_due.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("unexpected result word: rgb %0d %0d %0d fading %0b", r, g, b, f);
      return;
    end
    exp_col = colours_due.pop_front();
    if (r !== exp_col.red || g !== exp_col.green || b !== exp_col.blue ||
        f !== exp_col.fading) begin
      errors++;
      if (errors <= 10)
        $display("mismatch at %0t: expected rgb %0d %0d %0d fading %0b, got %0d %0d %0d %0b",
                 $realtime, exp_col.red, exp_col.green, exp_col.blue, exp_col.fading,
                 r, g, b, f);
    end
  endfunction
endclass

module tb_rgb_linear_fade_engine_top;
  import rlfe_pkg::*;

  localparam logic [1:0] REQ_SPARE = 2'd3;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic [1:0]         req_type;
  logic [LEVEL_W-1:0] in_red;
  logic [LEVEL_W-1:0] in_green;
  logic [LEVEL_W-1:0] in_blue;
  logic [LEVEL_W-1:0] fade_steps;
  logic               out_valid;
  logic               out_ready;
  logic [LEVEL_W-1:0] out_red;
  logic [LEVEL_W-1:0] out_green;
  logic [LEVEL_W-1:0] out_blue;
  logic               fading;

  fade_scoreboard sb;
  int             words_sent;
  bit             idle_on;

  rgb_linear_fade_engine_top dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .req_type   (req_type),
    .in_red     (in_red),
    .in_green   (in_green),
    .in_blue    (in_blue),
    .fade_steps (fade_steps),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_red    (out_red),
    .out_green  (out_green),
    .out_blue   (out_blue),
    .fading     (fading)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic logic [7:0] pick_level();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return 8'd0;
    if (sel == 1) return 8'd255;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_word(logic [1:0] kind, logic [7:0] r, logic [7:0] g, logic [7:0] b,
                           logic [7:0] steps);
    int gap;
    @(negedge clk);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 3);
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    req_type = kind;
    in_red = r;
    in_green = g;
    in_blue = b;
    fade_steps = steps;
    do @(posedge clk); while (!in_ready);
    sb.note_request(kind, r, g, b, steps);
    words_sent++;
  endtask

  task automatic send_ticks(int count);
    for (int i = 0; i < count; i++)
      send_word(REQ_TICK, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // receiver: random stall bursts while idling is on
  initial begin
    int stall_left;
    stall_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rst) begin
        out_ready = 1'b0;
      end else if (stall_left > 0) begin
        out_ready = 1'b0;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_ready = 1'b0;
        stall_left = $urandom_range(1, 3) - 1;
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_result(out_red, out_green, out_blue, fading);
  end

  initial begin
    #10_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    int          mode;
    int          steps;
    int          ticks;
    logic [1:0]  kind;
    sb = new();
    words_sent = 0;
    idle_on = 1'b1;
    rst = 1'b1;
    in_valid = 1'b0;
    req_type = REQ_TICK;
    in_red = '0;
    in_green = '0;
    in_blue = '0;
    fade_steps = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed
    send_ticks(1);
    send_word(REQ_SET, 8'd255, 8'd255, 8'd255, 8'd0);
    send_word(REQ_SET, 8'd0, 8'd0, 8'd0, 8'd255);
    send_word(REQ_START, 8'd255, 8'd0, 8'd128, 8'd0);
    send_word(REQ_START, 8'd255, 8'd255, 8'd255, 8'd1);
    send_ticks(1);
    send_word(REQ_START, 8'd0, 8'd0, 8'd0, 8'd255);
    send_ticks(3);
    send_word(REQ_START, 8'd128, 8'd64, 8'd200, 8'd3);
    send_word(REQ_SPARE, 8'd255, 8'd255, 8'd255, 8'd255);
    send_ticks(4);
    send_word(REQ_START, 8'd255, 8'd0, 8'd255, 8'd4);
    send_ticks(1);
    send_word(REQ_SET, 8'd17, 8'd200, 8'd99, 8'd170);
    send_ticks(1);
    send_word(REQ_START, 8'd0, 8'd255, 8'd0, 8'd2);
    send_ticks(2);

    // random: mostly whole fades, some interrupted, some noise
    while (words_sent < 1350) begin
      idle_on = (words_sent < 1200) && ((words_sent / 150) % 4 != 3);
      mode = $urandom_range(0, 9);
      if (mode < 2) begin
        send_word(REQ_SET, pick_level(), pick_level(), pick_level(), 8'($urandom));
        send_ticks($urandom_range(0, 2));
      end else if (mode < 8) begin
        steps = ($urandom_range(0, 11) == 0) ? $urandom_range(17, 255) : $urandom_range(1, 16);
        ticks = ($urandom_range(0, 2) == 0) ? $urandom_range(0, steps)
                                            : steps + $urandom_range(0, 2);
        send_word(REQ_START, pick_level(), pick_level(), pick_level(), 8'(steps));
        send_ticks(ticks);
      end else begin
        kind = 2'($urandom_range(0, 3));
        steps = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 255);
        send_word(kind, pick_level(), pick_level(), pick_level(), 8'(steps));
      end
    end
    idle_on = 1'b0;
    @(negedge clk);
    in_valid = 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

>>> rgb_linear_fade_engine_top.f
+incdir+design
design/rlfe_pkg.sv
design/rlfe_div.sv
design/rgb_linear_fade_engine_top.sv
tb/tb_rgb_linear_fade_engine_top.sv
